/* design/rrlu_pkg.sv */
// Shared types and constants for the RGB row linear upscaler.
// Used by rrlu_ctrl, rrlu_datapath and rgb_row_linear_upscaler_unit.
// Depends on nothing else.
package rrlu_pkg;

    // Row geometry.
    localparam int MAX_ROW   = 4096;
    localparam int COUNT_W   = $clog2(MAX_ROW + 1);

    // Configuration register widths and reset values.
    localparam int SCALE_W   = 13;
    localparam int STEP_W    = 17;
    localparam logic [SCALE_W-1:0] SCALE_RESET = 13'd256;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 17'd65536;

    // Configuration port.
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q8 = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_Q16 = 1'b1;

    // Source position in Q16.16.
    localparam int POS_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int POS_INT_W = POS_W - FRAC_W;

    // Output counting and the per-pixel result cap.
    localparam int EMIT_W    = 20;
    localparam int RES_CAP   = 64;
    localparam int NRES_W    = $clog2(RES_CAP + 1);

    // Row total: (scale_q8 * count + 128) >> 8.
    localparam int TOTAL_SHIFT  = 8;
    localparam int TOTAL_PROD_W = SCALE_W + COUNT_W;
    localparam int TOTAL_W      = TOTAL_PROD_W + 1 - TOTAL_SHIFT;
    localparam int TOTAL_ROUND  = 128;
    localparam int CMP_W        = (TOTAL_W > EMIT_W) ? TOTAL_W : EMIT_W;

    // Channel mixing: a*65536 + (b-a)*f + 32768, signed intermediate.
    localparam int MIX_W     = 26;
    localparam int MIX_ROUND = 32768;
    localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

    // Three 8-bit color channels, index 2 is red, index 0 is blue.
    typedef logic [2:0][7:0] rgb_t;

    // Beat payloads.
    typedef struct packed {
        logic [31:0] pixel_in;
        logic        last_in;
    } rrlu_in_t;

    typedef struct packed {
        logic [31:0] pixel_out;
        logic        last_out;
    } rrlu_out_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;          // latch an accepted input beat
        logic calc_total;    // compute the row output total
        logic put;           // launch one output mix and advance position
        logic pair_sel;      // 1: mix previous and current, 0: current only
        logic release_out;   // move the finished mix into the output register
        logic release_last;  // flag the released beat as the row's final one
        logic advance_row;   // non-last pixel done: shift current to previous
        logic finish_row;    // last pixel done: clear row state
    } rrlu_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic drop;          // overlong row, non-last pixel: discard
        logic last;          // current pixel closes the row
        logic loop1_ok;      // an interpolated output is due
        logic loop2_ok;      // a padding output is due
        logic empty;         // last pixel has given no output yet
        logic out_free;      // output register can take a beat
    } rrlu_status_t;

endpackage

/* design/rgb_row_linear_upscaler_unit.sv */
// Top level of the RGB row linear upscaler.
// Depends on rrlu_pkg, rrlu_ctrl and rrlu_datapath.
//
// Usage:
//   The s_ channel takes one source pixel per beat (0xAARRGGBB, alpha ignored),
//   with last_in set on the final pixel of a row. The m_ channel gives the
//   upscaled pixels (0xFFRRGGBB), with last_out set on the row's final beat.
//   Program scale_q8 (index 0) and step_q16 (index 1) through cfg_we while
//   the block is idle; reset sets both to 1.0.
//   One pixel is worked on at a time: acceptance, a setup step for the row
//   total, then one step per output beat and a closing step. The first output
//   of a pixel passes the row-total setup and the product registers before it
//   reaches the output register. The rate is set by the single shared mixer,
//   which produces one output per cycle while the output register is free.
//   When the receiver stalls, the finished beat waits in the output register
//   and the next mix waits behind it; a new pixel is still accepted while the
//   last beat of the previous one waits to be taken.
//   Reset clears the row state and empties the output register.
module rgb_row_linear_upscaler_unit
    import rrlu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  rrlu_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rrlu_out_t             m_data
);

    rrlu_cmd_t    cmd;
    rrlu_status_t status;

    // Sequencing of each pixel beat.
    rrlu_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Row state, mixer and output register.
    rrlu_datapath u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* design/rrlu_ctrl.sv */
// Controller of the RGB row linear upscaler: sequences one input pixel at a time.
// Depends on rrlu_pkg for the command and status structs.
module rrlu_ctrl
    import rrlu_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_valid,
    output logic         s_ready,
    input  rrlu_status_t status,
    output rrlu_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_START,
        ST_CHECK
    } state_t;

    state_t state_reg;
    logic   phase_reg;    // padding phase of the last pixel has begun
    logic   pending_reg;  // a mix sits in the datapath product registers

    logic go_pair;
    logic go_pad;
    logic go;
    logic stall;

    // Pick the next output kind; interpolated outputs come before padding.
    always_comb begin
        go_pair = !phase_reg && status.loop1_ok;
        go_pad  = status.loop2_ok || status.empty;
        go      = go_pair || go_pad;
        stall   = pending_reg && !status.out_free;
    end

    // Commands decoded from the state.
    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
            end
            ST_START: begin
                cmd.calc_total = 1'b1;
            end
            ST_CHECK: begin
                if (!stall) begin
                    cmd.release_out  = pending_reg;
                    cmd.release_last = status.last && !go;
                    cmd.put          = go;
                    cmd.pair_sel     = go_pair;
                    cmd.advance_row  = !go && !status.last;
                    cmd.finish_row   = !go && status.last;
                end
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

    // State and registered control flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            phase_reg   <= 1'b0;
            pending_reg <= 1'b0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_valid) begin
                        state_reg   <= ST_START;
                        phase_reg   <= 1'b0;
                        pending_reg <= 1'b0;
                    end
                end
                ST_START: begin
                    state_reg <= status.drop ? ST_IDLE : ST_CHECK;
                end
                ST_CHECK: begin
                    if (!stall) begin
                        pending_reg <= go;
                        if (go && !go_pair) begin
                            phase_reg <= 1'b1;
                        end
                        if (!go) begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

/* design/rrlu_datapath.sv */
// Datapath of the RGB row linear upscaler: row state, channel mixers, output register.
// Depends on rrlu_pkg; driven by rrlu_ctrl through rrlu_cmd_t.
module rrlu_datapath
    import rrlu_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    input  rrlu_in_t              s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output rrlu_out_t             m_data,
    input  rrlu_cmd_t             cmd,
    output rrlu_status_t          status
);

    // Configuration and row state.
    logic [SCALE_W-1:0] scale_reg;
    logic [STEP_W-1:0]  step_reg;
    rgb_t               prev_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [EMIT_W-1:0]  emitted_reg;
    logic               out_valid_reg;

    // Per-pixel working registers.
    rgb_t               cur_reg;
    logic               last_reg;
    logic               overflow_reg;
    logic [COUNT_W-1:0] n_reg;
    logic [TOTAL_W-1:0] total_reg;
    logic [NRES_W-1:0]  nres_reg;
    rgb_t               base_reg;
    logic signed [MIX_W-1:0] prod_reg [3];
    rrlu_out_t          out_data_reg;

    logic                    overflow;
    logic [COUNT_W-1:0]      n_plus1;
    logic [TOTAL_PROD_W:0]   total_sum;
    logic [POS_INT_W-1:0]    pos_int;
    logic                    below_total;
    logic                    room;
    rgb_t                    left_pix;
    logic signed [FRAC_W:0]  frac_s;
    logic signed [8:0]       diff [3];
    logic signed [MIX_W-1:0] prod_next [3];
    logic signed [MIX_W-1:0] mix_sum [3];
    rgb_t                    mixed;

    // Row bookkeeping.
    always_comb begin
        overflow  = count_reg >= COUNT_W'(MAX_ROW);
        n_plus1   = n_reg + COUNT_W'(1);
        total_sum = (TOTAL_PROD_W+1)'(scale_reg) * (TOTAL_PROD_W+1)'(n_plus1)
                  + (TOTAL_PROD_W+1)'(TOTAL_ROUND);
        pos_int     = pos_reg[POS_W-1:FRAC_W];
        below_total = CMP_W'(emitted_reg) < CMP_W'(total_reg);
        room        = nres_reg < NRES_W'(RES_CAP);
    end

    // Status toward the controller.
    always_comb begin
        status.drop     = overflow_reg && !last_reg;
        status.last     = last_reg;
        status.loop1_ok = (n_reg != '0) && (pos_int < POS_INT_W'(n_reg))
                        && (!last_reg || below_total) && room;
        status.loop2_ok = last_reg && below_total && room;
        status.empty    = last_reg && (nres_reg == '0);
        status.out_free = !out_valid_reg || m_ready;
    end

    // Mix products: a*65536 + (b-a)*f, the difference term multiplied here.
    always_comb begin
        left_pix = cmd.pair_sel ? prev_reg : cur_reg;
        frac_s   = $signed({1'b0, pos_reg[FRAC_W-1:0]});
        for (int c = 0; c < 3; c++) begin
            diff[c]      = $signed({1'b0, cur_reg[c]}) - $signed({1'b0, left_pix[c]});
            prod_next[c] = MIX_W'(diff[c]) * MIX_W'(frac_s);
        end
    end

    // Sum and round the registered products.
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            mix_sum[c] = $signed({2'b00, base_reg[c], 16'h0000}) + prod_reg[c]
                       + MIX_W'(MIX_ROUND);
            mixed[c]   = mix_sum[c][23:16];
        end
    end

    // Registers with reset: configuration, row state, output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scale_reg     <= SCALE_RESET;
            step_reg      <= STEP_RESET;
            prev_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            emitted_reg   <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_SCALE_Q8: scale_reg <= cfg_wdata[SCALE_W-1:0];
                    REG_STEP_Q16: step_reg  <= cfg_wdata[STEP_W-1:0];
                    default: begin
                        scale_reg <= scale_reg;
                    end
                endcase
            end
            if (cmd.put) begin
                pos_reg     <= pos_reg + POS_W'(step_reg);
                emitted_reg <= emitted_reg + EMIT_W'(1);
            end
            if (cmd.advance_row) begin
                prev_reg  <= cur_reg;
                count_reg <= n_plus1;
            end
            if (cmd.finish_row) begin
                prev_reg    <= '0;
                count_reg   <= '0;
                pos_reg     <= '0;
                emitted_reg <= '0;
            end
            if (cmd.release_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working and payload registers, loaded only under command.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cur_reg      <= overflow ? prev_reg : rgb_t'(s_data.pixel_in[23:0]);
            n_reg        <= overflow ? COUNT_W'(MAX_ROW - 1) : count_reg;
            overflow_reg <= overflow;
            last_reg     <= s_data.last_in;
            nres_reg     <= '0;
        end
        if (cmd.calc_total) begin
            total_reg <= total_sum[TOTAL_PROD_W:TOTAL_SHIFT];
        end
        if (cmd.put) begin
            nres_reg <= nres_reg + NRES_W'(1);
            base_reg <= left_pix;
            for (int c = 0; c < 3; c++) begin
                prod_reg[c] <= prod_next[c];
            end
        end
        if (cmd.release_out) begin
            out_data_reg.pixel_out <= {ALPHA_OPAQUE, mixed[2], mixed[1], mixed[0]};
            out_data_reg.last_out  <= cmd.release_last;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

endmodule
